// ----- src/lfr_pkg.sv -----
// Package for the LIN frame receiver: frame constants, result status codes,
// register indexes, controller states and the controller/datapath handshake structs.
// No dependencies; every other file of the block depends on it.
package lfr_pkg;

  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam int unsigned HEADER_TRAILER = 3;
  localparam int unsigned SLOT_COUNT     = MAX_DATA_BYTES + HEADER_TRAILER;
  localparam int unsigned SLOT_IDX_W     = $clog2(SLOT_COUNT + 1);
  localparam int unsigned LEN_W          = 4;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;

  // Status of a result.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD      = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_LEN    = 2'd0,
    REG_EXPECTED_ID = 2'd1,
    REG_MATCH_ID    = 2'd2,
    REG_WHOLE_FRAME = 2'd3
  } reg_idx_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the input request into the frame state
    logic step;    // load the next result into the output register
  } lfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic report;  // the request being accepted closes a frame
    logic last;    // the result being loaded is the final one of its report
  } lfr_sts_t;

endpackage

// ----- src/lfr_in_if.sv -----
// Input channel of the LIN frame receiver: valid/ready plus one bus event.
// Depends on lfr_pkg for the byte width.
interface lfr_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [lfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// ----- src/lfr_out_if.sv -----
// Result channel of the LIN frame receiver: valid/ready plus one frame slot.
// Depends on lfr_pkg for the byte width.
interface lfr_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [lfr_pkg::BYTE_W-1:0] slot_value;
  logic                     slot_valid;
  logic                     last;

  modport source (output valid, output status, output slot_value, output slot_valid,
                  output last, input ready);
  modport sink   (input valid, input status, input slot_value, input slot_valid,
                  input last, output ready);
endinterface

// ----- src/lfr_cfg_if.sv -----
// Configuration write channel of the LIN frame receiver: valid/ready, index, data.
// Depends on lfr_pkg for the index and data widths.
interface lfr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lfr_pkg::CFG_IDX_W-1:0] index;
  logic [lfr_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/lfr_ctrl.sv -----
// Controller of the LIN frame receiver: accepts input requests and sequences
// the results of a frame report into the output register. Depends on lfr_pkg.
module lfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output lfr_pkg::lfr_cmd_t cmd_o,
  input  lfr_pkg::lfr_sts_t sts_i
);
  import lfr_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands. Input is taken only between reports; while a
  // report runs, a new result is loaded whenever the output register frees up.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.report) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.step  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- src/lfr_datapath.sv -----
// Datapath of the LIN frame receiver: configuration registers, slot store,
// byte count, report bookkeeping and the output register. Depends on lfr_pkg.
module lfr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [lfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lfr_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                          action_i,
  input  logic [lfr_pkg::BYTE_W-1:0]    rx_byte_i,
  input  lfr_pkg::lfr_cmd_t             cmd_i,
  output lfr_pkg::lfr_sts_t             sts_o,
  output logic [1:0]                    status_o,
  output logic [lfr_pkg::BYTE_W-1:0]    slot_value_o,
  output logic                          slot_valid_o,
  output logic                          last_o
);
  import lfr_pkg::*;

  localparam logic [SLOT_IDX_W-1:0] SlotCount = SLOT_IDX_W'(SLOT_COUNT);
  localparam logic [SLOT_IDX_W-1:0] HdrTrl    = SLOT_IDX_W'(HEADER_TRAILER);
  localparam logic [LEN_W-1:0]      MaxLen    = LEN_W'(MAX_DATA_BYTES);

  // Configuration registers.
  logic [LEN_W-1:0]  data_len_q;
  logic [BYTE_W-1:0] expected_id_q;
  logic              match_id_q;
  logic              whole_frame_q;

  // Frame state.
  logic [BYTE_W-1:0]     slots_q [SLOT_COUNT];
  logic [BYTE_W-1:0]     id_q;
  logic [SLOT_IDX_W-1:0] cnt_q, cnt_d;

  // Report bookkeeping.
  logic [SLOT_IDX_W-1:0] rep_cnt_q, rep_cnt_d;
  status_e               kind_q, kind_d;
  logic [SLOT_IDX_W-1:0] idx_q;

  // Output register.
  status_e           stat_q;
  logic [BYTE_W-1:0] val_q;
  logic              vld_q;
  logic              last_q;

  logic [LEN_W-1:0]      eff_len;
  logic [SLOT_IDX_W-1:0] total;
  logic [SLOT_IDX_W-1:0] next_cnt;
  logic [SLOT_IDX_W-1:0] emit_end;
  logic                  is_sync;
  logic                  wr_en;
  logic [SLOT_IDX_W-1:0] wr_idx;
  logic                  report;
  logic                  slot_hit;
  logic                  emit_last;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_len_q    <= MaxLen;
      expected_id_q <= '0;
      match_id_q    <= 1'b1;
      whole_frame_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_DATA_LEN:    data_len_q    <= cfg_data_i[LEN_W-1:0];
        REG_EXPECTED_ID: expected_id_q <= cfg_data_i;
        REG_MATCH_ID:    match_id_q    <= cfg_data_i[0];
        REG_WHOLE_FRAME: whole_frame_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Data length clamped to 1..MAX_DATA_BYTES, and the frame size in slots.
  always_comb begin
    if (data_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (data_len_q > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = data_len_q;
    end
  end
  assign total = SLOT_IDX_W'(eff_len) + HdrTrl;

  // Decision for one accepted bus event: where the byte goes, whether it
  // closes a frame, and how many slots the closed frame holds.
  assign is_sync  = (rx_byte_i == SYNC_BYTE);
  assign next_cnt = cnt_q + SLOT_IDX_W'(1);

  always_comb begin
    cnt_d     = cnt_q;
    rep_cnt_d = cnt_q;
    report    = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = cnt_q;
    priority if (action_i) begin
      report = 1'b1;
      cnt_d  = '0;
    end else if (cnt_q == '0) begin
      if (is_sync) begin
        wr_en  = 1'b1;
        wr_idx = '0;
        cnt_d  = SLOT_IDX_W'(1);
      end
    end else if (is_sync) begin
      report = 1'b1;
      wr_en  = 1'b1;
      wr_idx = '0;
      cnt_d  = SLOT_IDX_W'(1);
    end else begin
      wr_en = (cnt_q < SlotCount);
      if (next_cnt >= total || next_cnt >= SlotCount) begin
        report    = 1'b1;
        rep_cnt_d = next_cnt;
        cnt_d     = '0;
      end else begin
        cnt_d = next_cnt;
      end
    end
  end

  // Kind of report for a closed frame.
  always_comb begin
    if (rep_cnt_d < HdrTrl) begin
      kind_d = STATUS_BAD;
    end else if (match_id_q && (id_q != expected_id_q)) begin
      kind_d = STATUS_MISMATCH;
    end else begin
      kind_d = STATUS_OK;
    end
  end

  // Byte count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.accept) begin
      cnt_q <= cnt_d;
    end
  end

  // Slot store and identifier copy; entries are read only below the count.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) begin
      slots_q[wr_idx[SLOT_IDX_W-1:0]] <= is_sync ? SYNC_BYTE : rx_byte_i;
      if (wr_idx == SLOT_IDX_W'(1)) begin
        id_q <= rx_byte_i;
      end
    end
  end

  // Report bookkeeping: captured at the closing request, the index then walks
  // the emitted slots.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && report) begin
      rep_cnt_q <= rep_cnt_d;
      kind_q    <= kind_d;
      idx_q     <= whole_frame_q ? '0 : SLOT_IDX_W'(2);
    end else if (cmd_i.step) begin
      idx_q <= idx_q + SLOT_IDX_W'(1);
    end
  end

  // End of the emitted range: all frame slots, or only the data slots.
  assign emit_end  = whole_frame_q ? total : (total - SLOT_IDX_W'(1));
  assign slot_hit  = (idx_q < rep_cnt_q);
  assign emit_last = (kind_q != STATUS_OK) || ((idx_q + SLOT_IDX_W'(1)) == emit_end);

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      stat_q <= kind_q;
      last_q <= emit_last;
      if ((kind_q == STATUS_OK) && slot_hit) begin
        val_q <= slots_q[idx_q];
        vld_q <= 1'b1;
      end else begin
        val_q <= '0;
        vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.report = report;
  assign sts_o.last   = emit_last;
  assign status_o     = stat_q;
  assign slot_value_o = val_q;
  assign slot_valid_o = vld_q;
  assign last_o       = last_q;

endmodule

// ----- src/lin_frame_receiver_core.sv -----
// LIN frame receiver, top level: joins the controller and the datapath to the
// input, result and configuration channels. Depends on lfr_pkg and the lfr_*_if interfaces.
//
// Usage:
//   rx_i carries one bus event per request: a received byte (action 0) or a
//   line-idle event (action 1). res_o carries frame reports, one slot per
//   request, with last set on the final request of each report. cfg_i writes
//   data_len, expected_id, match_id and whole_frame (indexes 0 to 3); it is
//   always ready and must be used only while no report is pending.
//   Requests that do not close a frame are accepted back to back. A request
//   that closes a frame is followed by its report of one to eleven results,
//   which the controller loads one slot per cycle, while res_o does not
//   stall, through a single output register once the report bookkeeping
//   has captured the frame. The next request is accepted in the cycle
//   after the final result is loaded.
//   When res_o stalls, the output register holds its result and the report
//   pauses; rx_i stays not ready until the report is fully loaded.
//   Reset clears the controller, the byte count (hunting for sync) and the
//   configuration to data_len 8, expected_id 0, match_id 1, whole_frame 1.
module lin_frame_receiver_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  lfr_in_if.sink    rx_i,
  lfr_out_if.source res_o,
  lfr_cfg_if.sink   cfg_i
);
  import lfr_pkg::*;

  lfr_cmd_t cmd;
  lfr_sts_t sts;

  assign cfg_i.ready = 1'b1;

  // Sequencing of requests and results.
  lfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_ready_o  (rx_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Frame state, configuration and result payload.
  lfr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .action_i     (rx_i.action),
    .rx_byte_i    (rx_i.rx_byte),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .status_o     (res_o.status),
    .slot_value_o (res_o.slot_value),
    .slot_valid_o (res_o.slot_valid),
    .last_o       (res_o.last)
  );

endmodule
